### hw/rtl/wspd_pkg.sv
// Shared types, constants and register codes of the pixel waveform driver.
package wspd_pkg;

	// Item kinds carried in tuser of the input stream.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Configuration register indexes (byte address divided by four).
	localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
	localparam logic [1:0] REG_BIT_PERIOD = 2'd1;
	localparam logic [1:0] REG_ZERO_HIGH  = 2'd2;
	localparam logic [1:0] REG_ONE_HIGH   = 2'd3;

	// Register reset values.
	localparam logic [7:0]  RST_BRIGHTNESS = 8'd255;
	localparam logic [15:0] RST_BIT_PERIOD = 16'd666;
	localparam logic [15:0] RST_ZERO_HIGH  = 16'd214;
	localparam logic [15:0] RST_ONE_HIGH   = 16'd444;

	// Geometry.
	localparam int MAX_PIXELS_DEF = 64;
	localparam int PIX_BITS       = 24;
	localparam int APB_ADDR_W     = 4;
	localparam int APB_DATA_W     = 32;

	// Register file contents handed to the sequencer.
	typedef struct packed {
		logic [7:0]  brightness;
		logic [15:0] bit_period;
		logic [15:0] zero_high;
		logic [15:0] one_high;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic pin_level;
		logic busy_res;
		logic frame_done;
		logic load_rejected;
	} res_t;

	// Sequencer state: idle, reading the next pixel word, or sending it.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SEND
	} st_t;

endpackage

### hw/rtl/wspd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module wspd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### hw/rtl/wspd_apb_regs.sv
// APB configuration registers: brightness and bit cell timing.
module wspd_apb_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wspd_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [wspd_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [wspd_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output wspd_pkg::cfg_t                      cfg
);

	wspd_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// Register writes on the access cycle of a write transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brightness <= wspd_pkg::RST_BRIGHTNESS;
			cfg_q.bit_period <= wspd_pkg::RST_BIT_PERIOD;
			cfg_q.zero_high  <= wspd_pkg::RST_ZERO_HIGH;
			cfg_q.one_high   <= wspd_pkg::RST_ONE_HIGH;
		end else if (wr_en) begin
			case (reg_idx)
				wspd_pkg::REG_BRIGHTNESS: cfg_q.brightness <= pwdata[7:0];
				wspd_pkg::REG_BIT_PERIOD: cfg_q.bit_period <= pwdata[15:0];
				wspd_pkg::REG_ZERO_HIGH:  cfg_q.zero_high  <= pwdata[15:0];
				wspd_pkg::REG_ONE_HIGH:   cfg_q.one_high   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		case (reg_idx)
			wspd_pkg::REG_BRIGHTNESS: prdata = 32'(cfg_q.brightness);
			wspd_pkg::REG_BIT_PERIOD: prdata = 32'(cfg_q.bit_period);
			wspd_pkg::REG_ZERO_HIGH:  prdata = 32'(cfg_q.zero_high);
			wspd_pkg::REG_ONE_HIGH:   prdata = 32'(cfg_q.one_high);
			default:                  prdata = '0;
		endcase
	end

endmodule

### hw/rtl/wspd_seq.sv
// Frame sequencer: stores scaled pixels and walks them out as timed bit cells.
module wspd_seq #(
	parameter int MAX_PIXELS = wspd_pkg::MAX_PIXELS_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            take,
	input  logic                                            op,
	input  logic [7:0]                                      red,
	input  logic [7:0]                                      green,
	input  logic [7:0]                                      blue,
	input  logic                                            last_pixel,
	input  wspd_pkg::cfg_t                                  cfg,
	input  logic [wspd_pkg::PIX_BITS-1:0]                   ram_rd_data,
	output logic                                            ram_wr_en,
	output logic [(MAX_PIXELS > 1 ? $clog2(MAX_PIXELS) : 1)-1:0] ram_wr_addr,
	output logic [wspd_pkg::PIX_BITS-1:0]                   ram_wr_data,
	output logic [(MAX_PIXELS > 1 ? $clog2(MAX_PIXELS) : 1)-1:0] ram_rd_addr,
	output logic                                            stall,
	output wspd_pkg::res_t                                  res
);

	localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CNT_W = $clog2(MAX_PIXELS + 1);
	localparam int CMP_W = CNT_W + 1;
	localparam logic [4:0] BIT_LAST = 5'(wspd_pkg::PIX_BITS - 1);

	wspd_pkg::st_t     state_q, state_d;
	logic [CNT_W-1:0]  stored_count_q, stored_count_d;
	logic [IDX_W-1:0]  read_index_q, read_index_d;
	logic [4:0]        bit_index_q, bit_index_d;
	logic [15:0]       cell_ticks_q, cell_ticks_d;

	logic              is_load;
	logic              is_tick;
	logic              full;
	logic              cur_bit;
	logic [15:0]       high_ticks;
	logic [16:0]       cell_next;
	logic [16:0]       period;
	logic              cell_end;
	logic              bit_last;
	logic              pix_last;

	// Colour gain: product of byte and brightness, top byte kept.
	function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] g);
		logic [15:0] p;
		p = 16'(c) * 16'(g);
		return p[15:8];
	endfunction

	// Cell timing for the current bit of the pixel word read from the store.
	assign is_load    = take && (op == wspd_pkg::OP_LOAD);
	assign is_tick    = take && (op == wspd_pkg::OP_TICK);
	assign full       = stored_count_q >= CNT_W'(MAX_PIXELS);
	assign cur_bit    = ram_rd_data[BIT_LAST - bit_index_q];
	assign high_ticks = cur_bit ? cfg.one_high : cfg.zero_high;
	assign cell_next  = {1'b0, cell_ticks_q} + 17'd1;
	assign period     = (cfg.bit_period == 16'd0) ? 17'd1 : {1'b0, cfg.bit_period};
	assign cell_end   = cell_next >= period;
	assign bit_last   = bit_index_q == BIT_LAST;
	assign pix_last   = (CMP_W'(read_index_q) + CMP_W'(1)) >= CMP_W'(stored_count_q);

	// Next state of the sequencer and its counters.
	always_comb begin
		state_d        = state_q;
		stored_count_d = stored_count_q;
		read_index_d   = read_index_q;
		bit_index_d    = bit_index_q;
		cell_ticks_d   = cell_ticks_q;
		case (state_q)
			wspd_pkg::ST_IDLE: begin
				if (is_load) begin
					if (!full) begin
						stored_count_d = stored_count_q + CNT_W'(1);
					end
					if (last_pixel) begin
						state_d      = wspd_pkg::ST_FETCH;
						read_index_d = '0;
						bit_index_d  = '0;
						cell_ticks_d = '0;
					end
				end
			end
			wspd_pkg::ST_FETCH: begin
				state_d = wspd_pkg::ST_SEND;
			end
			wspd_pkg::ST_SEND: begin
				if (is_tick) begin
					if (cell_end) begin
						cell_ticks_d = '0;
						if (bit_last) begin
							bit_index_d = '0;
							if (pix_last) begin
								state_d        = wspd_pkg::ST_IDLE;
								stored_count_d = '0;
								read_index_d   = '0;
							end else begin
								state_d      = wspd_pkg::ST_FETCH;
								read_index_d = read_index_q + IDX_W'(1);
							end
						end else begin
							bit_index_d = bit_index_q + 5'd1;
						end
					end else begin
						cell_ticks_d = cell_next[15:0];
					end
				end
			end
			default: begin
				state_d = wspd_pkg::ST_IDLE;
			end
		endcase
	end

	// Store access and result of the item taken in this cycle.
	always_comb begin
		ram_wr_en   = is_load && (state_q == wspd_pkg::ST_IDLE) && !full;
		ram_wr_addr = stored_count_q[IDX_W-1:0];
		ram_wr_data = {scale(green, cfg.brightness), scale(red, cfg.brightness),
			scale(blue, cfg.brightness)};
		ram_rd_addr = read_index_q;
		stall       = state_q == wspd_pkg::ST_FETCH;
		res         = '0;
		case (state_q)
			wspd_pkg::ST_IDLE: begin
				if (is_load) begin
					res.busy_res      = last_pixel;
					res.load_rejected = full;
				end
			end
			wspd_pkg::ST_SEND: begin
				if (is_load) begin
					res.busy_res      = 1'b1;
					res.load_rejected = 1'b1;
				end else begin
					res.pin_level  = {1'b0, cell_ticks_q} < {1'b0, high_ticks};
					res.busy_res   = 1'b1;
					res.frame_done = cell_end && bit_last && pix_last;
				end
			end
			default: ;
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= wspd_pkg::ST_IDLE;
			stored_count_q <= '0;
			read_index_q   <= '0;
			bit_index_q    <= '0;
			cell_ticks_q   <= '0;
		end else begin
			state_q        <= state_d;
			stored_count_q <= stored_count_d;
			read_index_q   <= read_index_d;
			bit_index_q    <= bit_index_d;
			cell_ticks_q   <= cell_ticks_d;
		end
	end

	// Nothing is taken while the store read for the next pixel is under way.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wspd_pkg::ST_FETCH) |-> !take)
		else $error("item taken during pixel fetch");

	// The store is only written between frames.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |-> (state_q == wspd_pkg::ST_IDLE))
		else $error("pixel store written while sending");

	// While a frame is out, the read pointer stays inside the stored frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != wspd_pkg::ST_IDLE) |-> (CMP_W'(read_index_q) < CMP_W'(stored_count_q)))
		else $error("read pointer beyond stored frame");

	// The end of a frame empties the store and returns to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && res.frame_done) |=> ((state_q == wspd_pkg::ST_IDLE) && (stored_count_q == '0)))
		else $error("frame end did not reset the sequencer");

endmodule

### hw/rtl/ws2812_pixel_waveform_driver_unit.sv
// Top level of the serial pixel waveform driver with its output register.
//
// Use: the input stream carries either a pixel load (tuser low, colours in
// tdata, tlast marking the final pixel of a frame) or one clock tick of the
// waveform (tuser high). Every accepted item yields exactly one result on
// the output stream: pin level, busy and rejection flags in tdata, with
// tlast raised on the tick that ends the last bit of the frame.
// A result is presented in the cycle after its input transfer, and one item
// is accepted per cycle unless the receiver stalls or a pixel word is read.
// At the start of each pixel of a frame the input is held off while the
// pixel word is read from the store (the single read port of the pixel RAM).
// Each pixel is sent as 24 bit cells.
// The output register lets a new item in while the previous result is taken
// in the same cycle; when the receiver stalls, the input is stalled too and
// no result is lost. The APB port configures brightness and cell timing and
// is to be written between frames only; the block itself does not enforce it.
// Reset sets the registers to their defaults, empties the frame store and
// leaves the line idle; no clearing pass over the pixel RAM is needed.
module ws2812_pixel_waveform_driver_unit #(
	parameter int MAX_PIXELS = wspd_pkg::MAX_PIXELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [23:0]                     s_tdata,  // red[7:0], green[15:8], blue[23:16]
	input  logic                            s_tlast,  // last_pixel
	input  logic                            s_tuser,  // op
	// Result stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,  // pin_level, busy_res, load_rejected, zeros
	output logic                            m_tlast,  // frame_done
	// Configuration port.
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wspd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [wspd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [wspd_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

	wspd_pkg::cfg_t               cfg;
	wspd_pkg::res_t               res;
	wspd_pkg::res_t               res_q;
	logic                         out_valid_q;
	logic                         take;
	logic                         stall;
	logic                         ram_wr_en;
	logic [IDX_W-1:0]             ram_wr_addr;
	logic [wspd_pkg::PIX_BITS-1:0] ram_wr_data;
	logic [IDX_W-1:0]             ram_rd_addr;
	logic [wspd_pkg::PIX_BITS-1:0] ram_rd_data;

	// Input handshake: room in the output register and no pixel fetch.
	assign s_tready = (!out_valid_q || m_tready) && !stall;
	assign take     = s_tvalid && s_tready;

	wspd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wspd_seq #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.op          (s_tuser),
		.red         (s_tdata[7:0]),
		.green       (s_tdata[15:8]),
		.blue        (s_tdata[23:16]),
		.last_pixel  (s_tlast),
		.cfg         (cfg),
		.ram_rd_data (ram_rd_data),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_addr (ram_rd_addr),
		.stall       (stall),
		.res         (res)
	);

	wspd_ram #(
		.WIDTH (wspd_pkg::PIX_BITS),
		.DEPTH (MAX_PIXELS)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Output register: filled on an input transfer, emptied on an output transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, res_q.load_rejected, res_q.busy_res, res_q.pin_level};
	assign m_tlast  = res_q.frame_done;

endmodule
